>>> hw/rtl/llrr_pkg.sv
// ----------------------------------------------------------------------------
// llrr_pkg
// Shared constants and command codes for the log line record ring.
// ----------------------------------------------------------------------------
package llrr_pkg;

  // defaults for the top-level parameters
  localparam int RING_BYTES_DEF = 8192;
  localparam int LINE_MAX_DEF   = 384;

  // record header: 8-byte stamp + 16-bit length
  localparam int HDR_BYTES = 8 + 2;

  // fixed port widths
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int MILLIS_W = 32;
  localparam int OFFSET_W = 13;
  localparam int COUNT_W  = 10;
  localparam int USED_W   = 14;
  localparam int TOTAL_W  = 32;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic [CMD_W-1:0] {
    CMD_FEED = 2'd0,
    CMD_PEEK = 2'd1,
    CMD_POP  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

endpackage

>>> hw/rtl/log_line_record_ring_core.sv
// ----------------------------------------------------------------------------
// log_line_record_ring_core
// Assembles text lines byte by byte and commits them as timestamped records
// into a byte ring, dropping the oldest records when space runs out.
// ----------------------------------------------------------------------------
// Per word: a feed byte goes to S_DONE, a peek reads in S_PEEK, a pop reads the
// length in S_REM0-S_REM2, and a newline commit drops old records the same way
// as needed, then writes the record through the single ring write port in
// S_WRITE. The result word turns valid as in_ready rises. One word in flight:
// a finished word waits in S_DONE for as long as the previous result is held.
// Reset (synchronous, rst_n low) empties the ring and the line buffer at once.
module log_line_record_ring_core #(
  parameter int RING_BYTES = llrr_pkg::RING_BYTES_DEF,
  parameter int LINE_MAX   = llrr_pkg::LINE_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [llrr_pkg::CMD_W-1:0]    in_cmd,
  input  logic [llrr_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [llrr_pkg::MILLIS_W-1:0] in_millis_now,
  input  logic [llrr_pkg::OFFSET_W-1:0] in_peek_offset,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [llrr_pkg::BYTE_W-1:0]   out_read_byte,
  output logic                          out_line_committed,
  output logic [llrr_pkg::COUNT_W-1:0]  out_lines_dropped_now,
  output logic [llrr_pkg::COUNT_W-1:0]  out_queued_lines,
  output logic [llrr_pkg::USED_W-1:0]   out_used_bytes,
  output logic [llrr_pkg::TOTAL_W-1:0]  out_dropped_total,
  output logic                          out_error
);

  localparam int AW  = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
  localparam int OW  = AW + 1;
  localparam int CW  = $clog2(RING_BYTES / llrr_pkg::HDR_BYTES + 1);
  localparam int LW  = $clog2(LINE_MAX + 1);
  localparam int LA  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int NW  = LW + 4;
  localparam int FW  = ((OW > NW) ? OW : NW) + 1;
  localparam int PW  = (OW > llrr_pkg::OFFSET_W) ? OW : llrr_pkg::OFFSET_W;
  localparam int SZW = 17;

  localparam logic [OW-1:0] RING_OW = OW'(RING_BYTES);
  localparam logic [FW-1:0] RING_FW = FW'(RING_BYTES);
  localparam logic [NW-1:0] HDR_NW  = NW'(llrr_pkg::HDR_BYTES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PEEK  = 8'b0000_0010,
    S_REM0  = 8'b0000_0100,
    S_REM1  = 8'b0000_1000,
    S_REM2  = 8'b0001_0000,
    S_CHECK = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // wraps base + inc around the ring; inc <= RING_BYTES
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [OW-1:0] inc);
    logic [OW-1:0] s;
    s = OW'(base) + inc;
    if (s >= RING_OW) s = s - RING_OW;
    return AW'(s);
  endfunction

  // memories
  logic [7:0] ring_mem [RING_BYTES];
  logic [7:0] line_mem [LINE_MAX];

  // control state
  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 wp_r, wp_nxt;
  logic [AW-1:0]                 oldest_r, oldest_nxt;
  logic [OW-1:0]                 occ_r, occ_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [llrr_pkg::TOTAL_W-1:0]  drop_r, drop_nxt;
  logic [LW-1:0]                 len_r, len_nxt;
  logic [llrr_pkg::MILLIS_W-1:0] prev_r, prev_nxt;
  logic [31:0]                   wrap_r, wrap_nxt;
  logic [NW-1:0]                 k_r, k_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // per-word result flags
  logic [7:0]    it_rbyte_r, it_rbyte_nxt;
  logic          it_commit_r, it_commit_nxt;
  logic [CW-1:0] it_drop_r, it_drop_nxt;
  logic          it_err_r, it_err_nxt;

  // captured input word
  llrr_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [llrr_pkg::MILLIS_W-1:0] millis_r, millis_nxt;
  logic [7:0]                    len_lo_r, len_lo_nxt;

  // output payload
  logic [7:0]                   o_rbyte_r, o_rbyte_nxt;
  logic                         o_commit_r, o_commit_nxt;
  logic [llrr_pkg::COUNT_W-1:0] o_drop_r, o_drop_nxt;
  logic [llrr_pkg::COUNT_W-1:0] o_queued_r, o_queued_nxt;
  logic [llrr_pkg::USED_W-1:0]  o_used_r, o_used_nxt;
  logic [llrr_pkg::TOTAL_W-1:0] o_total_r, o_total_nxt;
  logic                         o_err_r, o_err_nxt;

  // memory ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_q;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic          lw_en;
  logic [LA-1:0] lw_addr;
  logic [LA-1:0] lr_addr;
  logic [7:0]    line_q;

  logic [NW-1:0]  need;
  logic           fits;
  logic           slot_free;
  logic [63:0]    stamp;
  logic [SZW-1:0] rec_sz;
  logic           take;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign need      = NW'(len_r) + HDR_NW;
  assign fits      = (FW'(occ_r) + FW'(need)) <= RING_FW;
  assign stamp     = {wrap_r, millis_r};
  assign rec_sz    = SZW'(llrr_pkg::HDR_BYTES) + SZW'({rd_q, len_lo_r});
  assign lr_addr   = (k_r >= NW'(9)) ? LA'(k_r - NW'(9)) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wp_r] <= wr_data;
    if (rd_en) rd_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lw_en) line_mem[lw_addr] <= in_data_byte;
    line_q <= line_mem[lr_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    oldest_nxt    = oldest_r;
    occ_nxt       = occ_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    len_nxt       = len_r;
    prev_nxt      = prev_r;
    wrap_nxt      = wrap_r;
    k_nxt         = k_r;
    it_rbyte_nxt  = it_rbyte_r;
    it_commit_nxt = it_commit_r;
    it_drop_nxt   = it_drop_r;
    it_err_nxt    = it_err_r;
    cmd_nxt       = cmd_r;
    millis_nxt    = millis_r;
    len_lo_nxt    = len_lo_r;
    o_rbyte_nxt   = o_rbyte_r;
    o_commit_nxt  = o_commit_r;
    o_drop_nxt    = o_drop_r;
    o_queued_nxt  = o_queued_r;
    o_used_nxt    = o_used_r;
    o_total_nxt   = o_total_r;
    o_err_nxt     = o_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = 1'b0;
    rd_addr       = oldest_r;
    wr_en         = 1'b0;
    wr_data       = line_q;
    lw_en         = 1'b0;
    lw_addr       = LA'(len_r);

    case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd_nxt       = llrr_pkg::cmd_t'(in_cmd);
          millis_nxt    = in_millis_now;
          it_rbyte_nxt  = '0;
          it_commit_nxt = 1'b0;
          it_drop_nxt   = '0;
          it_err_nxt    = 1'b0;
          state_nxt     = S_DONE;
          case (llrr_pkg::cmd_t'(in_cmd))
            llrr_pkg::CMD_FEED: begin
              if (in_data_byte == llrr_pkg::CHAR_LF) begin
                if (len_r != '0) state_nxt = S_CHECK;
              end else if (in_data_byte != llrr_pkg::CHAR_CR) begin
                if (len_r < LW'(LINE_MAX)) begin
                  lw_en   = 1'b1;
                  len_nxt = len_r + LW'(1);
                end
              end
            end
            llrr_pkg::CMD_PEEK: begin
              if (PW'(in_peek_offset) < PW'(occ_r)) begin
                rd_en     = 1'b1;
                rd_addr   = ring_add(oldest_r, OW'(in_peek_offset));
                state_nxt = S_PEEK;
              end else begin
                it_err_nxt = 1'b1;
              end
            end
            llrr_pkg::CMD_POP: begin
              if (count_r != '0) state_nxt = S_REM0;
              else               it_err_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_PEEK: begin
        it_rbyte_nxt = rd_q;
        state_nxt    = S_DONE;
      end

      // length field sits at bytes 8 and 9 of the oldest record
      S_REM0: begin
        rd_en     = 1'b1;
        rd_addr   = ring_add(oldest_r, OW'(8));
        state_nxt = S_REM1;
      end

      S_REM1: begin
        rd_en      = 1'b1;
        rd_addr    = ring_add(oldest_r, OW'(9));
        len_lo_nxt = rd_q;
        state_nxt  = S_REM2;
      end

      S_REM2: begin
        if (rec_sz > SZW'(occ_r)) begin
          // corrupt length: empty the ring
          oldest_nxt = wp_r;
          occ_nxt    = '0;
          count_nxt  = '0;
        end else begin
          oldest_nxt = ring_add(oldest_r, OW'(rec_sz));
          occ_nxt    = occ_r - OW'(rec_sz);
          count_nxt  = count_r - CW'(1);
        end
        state_nxt = (cmd_r == llrr_pkg::CMD_POP) ? S_DONE : S_CHECK;
      end

      S_CHECK: begin
        if (!fits && count_r != '0) begin
          drop_nxt    = drop_r + 32'd1;
          it_drop_nxt = it_drop_r + CW'(1);
          state_nxt   = S_REM0;
        end else if (!fits) begin
          len_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          if (millis_r < prev_r) wrap_nxt = wrap_r + 32'd1;
          prev_nxt  = millis_r;
          k_nxt     = '0;
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        wr_en = 1'b1;
        if (k_r < NW'(8))       wr_data = stamp[{k_r[2:0], 3'b000} +: 8];
        else if (k_r == NW'(8)) wr_data = 8'(16'(len_r));
        else if (k_r == NW'(9)) wr_data = 8'(16'(len_r) >> 8);
        else                    wr_data = line_q;
        wp_nxt = ring_add(wp_r, OW'(1));
        k_nxt  = k_r + NW'(1);
        if (k_r == need - NW'(1)) begin
          occ_nxt       = occ_r + OW'(need);
          count_nxt     = count_r + CW'(1);
          it_commit_nxt = 1'b1;
          len_nxt       = '0;
          state_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          o_rbyte_nxt   = it_rbyte_r;
          o_commit_nxt  = it_commit_r;
          o_drop_nxt    = llrr_pkg::COUNT_W'(it_drop_r);
          o_queued_nxt  = llrr_pkg::COUNT_W'(count_r);
          o_used_nxt    = llrr_pkg::USED_W'(occ_r);
          o_total_nxt   = drop_r;
          o_err_nxt     = it_err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      oldest_r    <= '0;
      occ_r       <= '0;
      count_r     <= '0;
      drop_r      <= '0;
      len_r       <= '0;
      prev_r      <= '0;
      wrap_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      it_rbyte_r  <= '0;
      it_commit_r <= 1'b0;
      it_drop_r   <= '0;
      it_err_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      oldest_r    <= oldest_nxt;
      occ_r       <= occ_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      len_r       <= len_nxt;
      prev_r      <= prev_nxt;
      wrap_r      <= wrap_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      it_rbyte_r  <= it_rbyte_nxt;
      it_commit_r <= it_commit_nxt;
      it_drop_r   <= it_drop_nxt;
      it_err_r    <= it_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    millis_r   <= millis_nxt;
    len_lo_r   <= len_lo_nxt;
    o_rbyte_r  <= o_rbyte_nxt;
    o_commit_r <= o_commit_nxt;
    o_drop_r   <= o_drop_nxt;
    o_queued_r <= o_queued_nxt;
    o_used_r   <= o_used_nxt;
    o_total_r  <= o_total_nxt;
    o_err_r    <= o_err_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_read_byte         = o_rbyte_r;
  assign out_line_committed    = o_commit_r;
  assign out_lines_dropped_now = o_drop_r;
  assign out_queued_lines      = o_queued_r;
  assign out_used_bytes        = o_used_r;
  assign out_dropped_total     = o_total_r;
  assign out_error             = o_err_r;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the log line record ring. Text lines, peeks and
// pops are driven over the valid/ready input channel, with random gaps on
// both sides. A tracker keeps its own copy of the ring and the line buffer,
// works out the result word of every accepted input word and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RAND_WORDS  = 1200;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RING_N      = llrr_pkg::RING_BYTES_DEF;
  localparam int LINE_N      = llrr_pkg::LINE_MAX_DEF;

  typedef struct {
    logic [llrr_pkg::BYTE_W-1:0]  read_byte;
    logic                         committed;
    logic [llrr_pkg::COUNT_W-1:0] dropped_now;
    logic [llrr_pkg::COUNT_W-1:0] queued;
    logic [llrr_pkg::USED_W-1:0]  used;
    logic [llrr_pkg::TOTAL_W-1:0] total;
    logic                         err;
  } ring_result_t;

  // Shadow of the ring: notes each accepted input word, checks each result.
  class ring_tracker;
    byte unsigned ring_mem [RING_N];
    byte unsigned line_buf [LINE_N];
    int unsigned  wr_ptr, head_ptr, held_bytes, held_recs, line_len;
    bit [31:0]    drops, last_ms, wraps;
    ring_result_t pending [$];
    int unsigned  mismatches;

    function new();
      wr_ptr = 0; head_ptr = 0; held_bytes = 0; held_recs = 0; line_len = 0;
      drops = 0; last_ms = 0; wraps = 0; mismatches = 0;
    endfunction

    function void retire_oldest();
      int unsigned len, sz;
      len = 32'({ring_mem[(head_ptr + 9) % RING_N],
                 ring_mem[(head_ptr + 8) % RING_N]});
      sz = llrr_pkg::HDR_BYTES + len;
      if (sz > held_bytes) begin
        head_ptr = wr_ptr;
        held_bytes = 0;
        held_recs = 0;
      end else begin
        head_ptr = (head_ptr + sz) % RING_N;
        held_bytes -= sz;
        held_recs--;
      end
    endfunction

    function void put_byte(byte unsigned b);
      ring_mem[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % RING_N;
    endfunction

    function bit commit_line(input bit [31:0] ms, output int unsigned dropped);
      int unsigned need;
      bit [63:0]   stamp;
      dropped = 0;
      need = llrr_pkg::HDR_BYTES + line_len;
      while (held_bytes + need > RING_N && held_recs > 0) begin
        retire_oldest();
        drops++;
        dropped++;
      end
      if (held_bytes + need > RING_N) return 1'b0;
      // millis going backwards between commits counts as a wrap
      if (ms < last_ms) wraps++;
      last_ms = ms;
      stamp = {wraps, ms};
      for (int i = 0; i < 8; i++) put_byte(stamp[8*i +: 8]);
      put_byte(line_len[7:0]);
      put_byte(line_len[15:8]);
      for (int i = 0; i < line_len; i++) put_byte(line_buf[i]);
      held_bytes += need;
      held_recs++;
      return 1'b1;
    endfunction

    function void take_word(llrr_pkg::cmd_t c, bit [7:0] b, bit [31:0] ms,
                            bit [12:0] off);
      ring_result_t r;
      int unsigned  dn;
      r = '{default: 0};
      dn = 0;
      case (c)
        llrr_pkg::CMD_FEED: begin
          if (b == llrr_pkg::CHAR_LF) begin
            if (line_len > 0) r.committed = commit_line(ms, dn);
            line_len = 0;
          end else if (b != llrr_pkg::CHAR_CR && line_len < LINE_N) begin
            line_buf[line_len] = b;
            line_len++;
          end
        end
        llrr_pkg::CMD_PEEK: begin
          if (off < held_bytes) r.read_byte = ring_mem[(head_ptr + off) % RING_N];
          else r.err = 1'b1;
        end
        llrr_pkg::CMD_POP: begin
          if (held_recs > 0) retire_oldest();
          else r.err = 1'b1;
        end
        default: ;
      endcase
      r.dropped_now = llrr_pkg::COUNT_W'(dn);
      r.queued = llrr_pkg::COUNT_W'(held_recs);
      r.used = llrr_pkg::USED_W'(held_bytes);
      r.total = drops;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
        mismatches++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_word(ring_result_t got);
      ring_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, expected none, got used_bytes %0d",
                 $time, got.used);
        return;
      end
      want = pending.pop_front();
      compare_field("read_byte", 64'(want.read_byte), 64'(got.read_byte));
      compare_field("line_committed", 64'(want.committed), 64'(got.committed));
      compare_field("lines_dropped_now", 64'(want.dropped_now), 64'(got.dropped_now));
      compare_field("queued_lines", 64'(want.queued), 64'(got.queued));
      compare_field("used_bytes", 64'(want.used), 64'(got.used));
      compare_field("dropped_total", 64'(want.total), 64'(got.total));
      compare_field("error", 64'(want.err), 64'(got.err));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [llrr_pkg::CMD_W-1:0]    in_cmd;
  logic [llrr_pkg::BYTE_W-1:0]   in_data_byte;
  logic [llrr_pkg::MILLIS_W-1:0] in_millis_now;
  logic [llrr_pkg::OFFSET_W-1:0] in_peek_offset;
  logic                          out_valid;
  logic                          out_ready;
  logic [llrr_pkg::BYTE_W-1:0]   out_read_byte;
  logic                          out_line_committed;
  logic [llrr_pkg::COUNT_W-1:0]  out_lines_dropped_now;
  logic [llrr_pkg::COUNT_W-1:0]  out_queued_lines;
  logic [llrr_pkg::USED_W-1:0]   out_used_bytes;
  logic [llrr_pkg::TOTAL_W-1:0]  out_dropped_total;
  logic                          out_error;

  ring_tracker tracker = new();
  int unsigned words_sent = 0;
  int unsigned words_out = 0;
  int unsigned cycles = 0;
  bit          send_calm = 1'b0;
  bit          sink_calm = 1'b0;
  logic [31:0] clock_ms;

  always #5 clk = ~clk;

  log_line_record_ring_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_cmd                (in_cmd),
    .in_data_byte          (in_data_byte),
    .in_millis_now         (in_millis_now),
    .in_peek_offset        (in_peek_offset),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_read_byte         (out_read_byte),
    .out_line_committed    (out_line_committed),
    .out_lines_dropped_now (out_lines_dropped_now),
    .out_queued_lines      (out_queued_lines),
    .out_used_bytes        (out_used_bytes),
    .out_dropped_total     (out_dropped_total),
    .out_error             (out_error)
  );

  always @(posedge clk) begin : port_monitor
    ring_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.read_byte   = out_read_byte;
      got.committed   = out_line_committed;
      got.dropped_now = out_lines_dropped_now;
      got.queued      = out_queued_lines;
      got.used        = out_used_bytes;
      got.total       = out_dropped_total;
      got.err         = out_error;
      tracker.check_word(got);
      words_out++;
    end
    if (rst_n && in_valid && in_ready)
      tracker.take_word(llrr_pkg::cmd_t'(in_cmd), in_data_byte, in_millis_now,
                        in_peek_offset);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] tick_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) clock_ms = $urandom;
    else if (r < 4) clock_ms = clock_ms - $urandom_range(1, 5000);
    else clock_ms = clock_ms + $urandom_range(0, 3);
    return clock_ms;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [12:0] rand_off();
    return 13'($urandom_range(0, 8191));
  endfunction

  // called and returns at a falling edge; valid stays up for a back-to-back word
  task automatic send_word(llrr_pkg::cmd_t c, logic [7:0] b, logic [31:0] ms,
                           logic [12:0] off);
    int unsigned gap;
    if (words_sent % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
    words_sent++;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cmd         = c;
    in_data_byte   = b;
    in_millis_now  = ms;
    in_peek_offset = off;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic feed_line(int unsigned len);
    byte unsigned b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0) b = llrr_pkg::CHAR_CR;
      else do b = rand_byte(); while (b == llrr_pkg::CHAR_LF);
      send_word(llrr_pkg::CMD_FEED, b, tick_ms(), rand_off());
    end
    send_word(llrr_pkg::CMD_FEED, llrr_pkg::CHAR_LF, tick_ms(), rand_off());
  endtask

  task automatic peek_any();
    logic [12:0] off;
    if (tracker.held_bytes > 0 && $urandom_range(0, 2) != 0)
      off = 13'($urandom_range(0, tracker.held_bytes - 1));
    else
      off = rand_off();
    send_word(llrr_pkg::CMD_PEEK, rand_byte(), tick_ms(), off);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
  endtask

  initial begin : result_sink
    int unsigned stall, turns;
    bit held;
    out_ready = 1'b0;
    held = 1'b0;
    turns = 0;
    wait (rst_n === 1'b1);
    forever begin
      // one long hold-off so the block backs up and stops taking words
      if (!held && words_out >= 400) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      if (turns % 100 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      turns++;
      stall = pick_gap(sink_calm);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned base, done, r, s, len;
    bit paused;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = llrr_pkg::CMD_NOP;
    in_data_byte   = '0;
    in_millis_now  = '0;
    in_peek_offset = '0;
    clock_ms       = 32'd100;
    paused         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty ring, blank line, CR, byte extremes, stamp wrap, peek edges
    send_word(llrr_pkg::CMD_NOP, 8'hFF, 32'hFFFF_FFFF, 13'h1FFF);
    send_word(llrr_pkg::CMD_POP, 8'h00, 32'd1, 13'd0);
    send_word(llrr_pkg::CMD_PEEK, 8'h00, 32'd2, 13'd0);
    send_word(llrr_pkg::CMD_FEED, llrr_pkg::CHAR_LF, 32'd3, 13'd0);
    send_word(llrr_pkg::CMD_FEED, llrr_pkg::CHAR_CR, 32'd4, 13'd0);
    send_word(llrr_pkg::CMD_FEED, 8'h00, 32'd5, 13'd0);
    send_word(llrr_pkg::CMD_FEED, 8'hFF, 32'd6, 13'd0);
    send_word(llrr_pkg::CMD_FEED, llrr_pkg::CHAR_CR, 32'd7, 13'd0);
    send_word(llrr_pkg::CMD_FEED, 8'h7F, 32'd8, 13'd0);
    send_word(llrr_pkg::CMD_FEED, llrr_pkg::CHAR_LF, 32'hFFFF_FFFF, 13'd0);
    send_word(llrr_pkg::CMD_FEED, 8'h41, 32'd9, 13'd0);
    send_word(llrr_pkg::CMD_FEED, llrr_pkg::CHAR_LF, 32'd5, 13'd0);
    send_word(llrr_pkg::CMD_PEEK, 8'h00, 32'd10, 13'd0);
    send_word(llrr_pkg::CMD_PEEK, 8'h00, 32'd11, 13'd8);
    send_word(llrr_pkg::CMD_PEEK, 8'h00, 32'd12, 13'd12);
    send_word(llrr_pkg::CMD_PEEK, 8'h00, 32'd13, 13'd23);
    send_word(llrr_pkg::CMD_PEEK, 8'h00, 32'd14, 13'd24);
    send_word(llrr_pkg::CMD_PEEK, 8'h00, 32'd15, 13'h1FFF);
    send_word(llrr_pkg::CMD_POP, 8'h00, 32'd16, 13'd0);
    send_word(llrr_pkg::CMD_POP, 8'h00, 32'd17, 13'd0);
    send_word(llrr_pkg::CMD_POP, 8'h00, 32'd18, 13'd0);
    send_word(llrr_pkg::CMD_NOP, 8'h00, 32'd0, 13'd0);
    wait_drained();

    // random: mixed traffic first, then mostly short lines
    base = words_sent;
    done = 0;
    while (done < RAND_WORDS) begin
      if (!paused && done >= RAND_WORDS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      if (done >= RAND_WORDS * 3 / 4) begin
        r = $urandom_range(0, 199);
        if (r < 180) feed_line($urandom_range(1, 2));
        else if (r == 180) feed_line($urandom_range(300, 420));
        else if (r < 196) peek_any();
        else send_word(llrr_pkg::CMD_NOP, rand_byte(), tick_ms(), rand_off());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          s = $urandom_range(0, 99);
          if (s < 8) len = 0;
          else if (s < 70) len = $urandom_range(1, 4);
          else if (s < 92) len = $urandom_range(5, 40);
          else if (s < 98) len = $urandom_range(41, 200);
          else len = $urandom_range(380, 400);
          feed_line(len);
        end else if (r < 84) peek_any();
        else if (r < 91) send_word(llrr_pkg::CMD_POP, rand_byte(), tick_ms(), rand_off());
        else if (r < 94) send_word(llrr_pkg::CMD_NOP, rand_byte(), tick_ms(), rand_off());
        else if (r < 97) send_word(llrr_pkg::CMD_FEED, llrr_pkg::CHAR_CR, tick_ms(),
                                   rand_off());
        else send_word(llrr_pkg::CMD_FEED, llrr_pkg::CHAR_LF, tick_ms(), rand_off());
      end
      done = words_sent - base;
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
